FILE: src/im2col_gather_unit_defines.svh
// ----------------------------------------------------------------------------
// im2col gather unit assertion macros
// Shared concurrent assertion forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef IM2COL_GATHER_UNIT_DEFINES_SVH
`define IM2COL_GATHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ICG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ICG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/icg_pkg.sv
// ----------------------------------------------------------------------------
// im2col gather package
// Item, result and configuration types, store sizing and shared helpers.
// ----------------------------------------------------------------------------
package icg_pkg;

  localparam int IMAGE_WORDS = 65536;
  localparam int ADDR_W      = $clog2(IMAGE_WORDS);

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;

  // Output size derivation: quotient of at most 10 bits, one bit per step
  localparam int DIV_STEPS = 10;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [8:0] DIM_SAT = 9'd511;

  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_SIZE   = 3'd3,
    REG_STEP_SIZE     = 3'd4,
    REG_PADDING       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] pixel_address;
    logic [31:0] pixel_value;
    logic [7:0]  image_channel;
    logic [3:0]  kernel_row;
    logic [3:0]  kernel_col;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
  } item_t;

  typedef struct packed {
    logic [31:0] element_value;
    logic [31:0] column_index;
    logic        is_padding;
    logic        range_error;
  } result_t;

  typedef struct packed {
    logic [8:0] image_height;
    logic [8:0] image_width;
    logic [8:0] channel_count;
    logic [4:0] kernel_size;
    logic [4:0] step_size;
    logic [3:0] padding;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  out_height;
    logic [8:0]  out_width;
    logic [17:0] plane;
  } dims_t;

  // Request presented to the store stage
  typedef struct packed {
    logic        valid;
    logic        is_fetch;
    logic        err;
    logic        pad;
    logic [26:0] addr_full;
    logic [31:0] prod;
    logic [17:0] pos;
    logic [15:0] waddr;
    logic [31:0] wdata;
  } mem_req_t;

  function automatic logic [4:0] eff_stride(input logic [4:0] step);
    return (step == 5'd0) ? 5'd1 : step;
  endfunction

endpackage

FILE: src/icg_ram.sv
// ----------------------------------------------------------------------------
// icg_ram
// Single-port synchronous RAM, registered read, read and write gated by en.
// ----------------------------------------------------------------------------
module icg_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/icg_dim_unit.sv
// ----------------------------------------------------------------------------
// icg_dim_unit
// Derives output height, width and plane size after a configuration write.
// ----------------------------------------------------------------------------
module icg_dim_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  icg_pkg::cfg_t cfg,
  output icg_pkg::dims_t dims,
  output logic          busy
);
  import icg_pkg::*;

  typedef enum logic [4:0] {
    D_IDLE   = 5'b00001,
    D_LOAD   = 5'b00010,
    D_DIVIDE = 5'b00100,
    D_STORE  = 5'b01000,
    D_PLANE  = 5'b10000
  } dim_state_t;

  dim_state_t state;
  logic [DIV_CNT_W-1:0] cnt;
  logic [4:0] divisor;
  logic [9:0] num_h, num_w;
  logic [4:0] rem_h, rem_w;
  logic       zero_h, zero_w;
  logic [9:0] span_h, span_w, kext;
  logic [14:0] step_h, step_w;

  // One restoring division step: shift a quotient bit into num
  function automatic logic [14:0] div_step(input logic [9:0] num, input logic [4:0] rem,
                                           input logic [4:0] dv);
    logic [5:0] shifted;
    logic       qbit;
    logic [4:0] r;
    shifted = {rem, num[9]};
    if (shifted >= {1'b0, dv}) begin
      qbit = 1'b1;
      r    = 5'(shifted - {1'b0, dv});
    end else begin
      qbit = 1'b0;
      r    = shifted[4:0];
    end
    return {num[8:0], qbit, r};
  endfunction

  function automatic logic [8:0] finish_dim(input logic zero, input logic [9:0] q);
    logic [10:0] inc;
    inc = {1'b0, q} + 11'd1;
    if (zero) begin
      return 9'd0;
    end else if (inc > {2'b0, DIM_SAT}) begin
      return DIM_SAT;
    end else begin
      return inc[8:0];
    end
  endfunction

  assign span_h = {1'b0, cfg.image_height} + {5'b0, cfg.padding, 1'b0};
  assign span_w = {1'b0, cfg.image_width} + {5'b0, cfg.padding, 1'b0};
  assign kext   = {5'b0, cfg.kernel_size};
  assign step_h = div_step(num_h, rem_h, divisor);
  assign step_w = div_step(num_w, rem_w, divisor);
  assign busy   = (state != D_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
      dims  <= '0;
    end else if (start) begin
      state <= D_LOAD;
    end else begin
      case (state)
        D_IDLE: begin
          state <= D_IDLE;
        end
        D_LOAD: begin
          cnt   <= '0;
          state <= D_DIVIDE;
        end
        D_DIVIDE: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= D_STORE;
          end
        end
        D_STORE: begin
          dims.out_height <= finish_dim(zero_h, num_h);
          dims.out_width  <= finish_dim(zero_w, num_w);
          state           <= D_PLANE;
        end
        D_PLANE: begin
          dims.plane <= {9'b0, dims.out_height} * {9'b0, dims.out_width};
          state      <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (state == D_LOAD) begin
      divisor <= eff_stride(cfg.step_size);
      zero_h  <= (span_h < kext);
      zero_w  <= (span_w < kext);
      num_h   <= span_h - kext;
      num_w   <= span_w - kext;
      rem_h   <= '0;
      rem_w   <= '0;
    end else if (state == D_DIVIDE) begin
      {num_h, rem_h} <= step_h;
      {num_w, rem_w} <= step_w;
    end
  end

endmodule

FILE: src/icg_fetch_pipe.sv
// ----------------------------------------------------------------------------
// icg_fetch_pipe
// Four address stages: range check, source pixel, kernel index, store address.
// ----------------------------------------------------------------------------
module icg_fetch_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              accept,
  input  icg_pkg::item_t    item,
  input  icg_pkg::cfg_t     cfg,
  input  icg_pkg::dims_t    dims,
  output icg_pkg::mem_req_t req
);
  import icg_pkg::*;

  typedef struct packed {
    logic        is_fetch;
    logic        err;
    logic [7:0]  ch;
    logic [3:0]  kr;
    logic [3:0]  kc;
    logic [7:0]  orow;
    logic [7:0]  ocol;
    logic [12:0] orow_s;
    logic [12:0] ocol_s;
    logic [12:0] ch_k;
    logic [15:0] waddr;
    logic [31:0] wdata;
  } s1_t;

  typedef struct packed {
    logic        is_fetch;
    logic        err;
    logic        pad;
    logic [3:0]  kc;
    logic [7:0]  ocol;
    logic [8:0]  row9;
    logic [8:0]  col9;
    logic [13:0] ka;
    logic [16:0] ch_h;
    logic [16:0] orow_w;
    logic [15:0] waddr;
    logic [31:0] wdata;
  } s2_t;

  typedef struct packed {
    logic        is_fetch;
    logic        err;
    logic        pad;
    logic [8:0]  col9;
    logic [18:0] kidx;
    logic [17:0] addr_a;
    logic [17:0] pos;
    logic [15:0] waddr;
    logic [31:0] wdata;
  } s3_t;

  logic v1, v2, v3, v4;
  s1_t s1, n1;
  s2_t s2, n2;
  s3_t s3, n3;
  mem_req_t s4, n4;

  logic [4:0]  stride;
  logic [13:0] row_sum, col_sum;
  logic signed [14:0] row, col;
  logic [18:0] kidx_mul;
  logic [36:0] prod_full;

  assign stride = eff_stride(cfg.step_size);

  // Range check and first products
  always_comb begin
    n1.is_fetch = (item.operation == OP_FETCH);
    n1.err = ({1'b0, item.image_channel} >= cfg.channel_count) ||
             ({1'b0, item.kernel_row} >= cfg.kernel_size) ||
             ({1'b0, item.kernel_col} >= cfg.kernel_size) ||
             ({1'b0, item.out_row} >= dims.out_height) ||
             ({1'b0, item.out_col} >= dims.out_width);
    n1.ch     = item.image_channel;
    n1.kr     = item.kernel_row;
    n1.kc     = item.kernel_col;
    n1.orow   = item.out_row;
    n1.ocol   = item.out_col;
    n1.orow_s = {5'b0, item.out_row} * {8'b0, stride};
    n1.ocol_s = {5'b0, item.out_col} * {8'b0, stride};
    n1.ch_k   = {5'b0, item.image_channel} * {8'b0, cfg.kernel_size};
    n1.waddr  = item.pixel_address;
    n1.wdata  = item.pixel_value;
  end

  // Source pixel and border test
  always_comb begin
    row_sum = {1'b0, s1.orow_s} + {10'b0, s1.kr};
    col_sum = {1'b0, s1.ocol_s} + {10'b0, s1.kc};
    row = $signed({1'b0, row_sum}) - $signed({11'b0, cfg.padding});
    col = $signed({1'b0, col_sum}) - $signed({11'b0, cfg.padding});
    n2.is_fetch = s1.is_fetch;
    n2.err      = s1.err;
    n2.pad      = row[14] || col[14] ||
                  (row[13:0] >= {5'b0, cfg.image_height}) ||
                  (col[13:0] >= {5'b0, cfg.image_width});
    n2.kc     = s1.kc;
    n2.ocol   = s1.ocol;
    n2.row9   = row[8:0];
    n2.col9   = col[8:0];
    n2.ka     = {1'b0, s1.ch_k} + {10'b0, s1.kr};
    n2.ch_h   = {9'b0, s1.ch} * {8'b0, cfg.image_height};
    n2.orow_w = {9'b0, s1.orow} * {8'b0, dims.out_width};
    n2.waddr  = s1.waddr;
    n2.wdata  = s1.wdata;
  end

  // Kernel index, partial address, in-plane position
  always_comb begin
    kidx_mul    = {5'b0, s2.ka} * {14'b0, cfg.kernel_size};
    n3.is_fetch = s2.is_fetch;
    n3.err      = s2.err;
    n3.pad      = s2.pad;
    n3.col9     = s2.col9;
    n3.kidx     = kidx_mul + {15'b0, s2.kc};
    n3.addr_a   = {1'b0, s2.ch_h} + {9'b0, s2.row9};
    n3.pos      = {1'b0, s2.orow_w} + {10'b0, s2.ocol};
    n3.waddr    = s2.waddr;
    n3.wdata    = s2.wdata;
  end

  // Plane offset and full store address
  always_comb begin
    prod_full    = {18'b0, s3.kidx} * {19'b0, dims.plane};
    n4.valid     = 1'b1;
    n4.is_fetch  = s3.is_fetch;
    n4.err       = s3.err;
    n4.pad       = s3.pad;
    n4.addr_full = {9'b0, s3.addr_a} * {18'b0, cfg.image_width} + {18'b0, s3.col9};
    n4.prod      = prod_full[31:0];
    n4.pos       = s3.pos;
    n4.waddr     = s3.waddr;
    n4.wdata     = s3.wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= n1;
      s2 <= n2;
      s3 <= n3;
      s4 <= n4;
    end
  end

  always_comb begin
    req       = s4;
    req.valid = v4;
  end

endmodule

FILE: src/im2col_gather_unit.sv
// A fetch result is offered after the fetch pipe and the registered store read.
// Throughput: one item per cycle while results are taken; the single port of
// the image store serves one write or one read per cycle and sets that figure.
// A configuration write holds off input while the output size is derived by
// a 10-step divider. Reset clears control and configuration only.
// ----------------------------------------------------------------------------
// im2col_gather_unit
// Convolution lowering gather: stores image words and returns column-matrix
// elements, zero for the padding border, with their linear column index.
// ----------------------------------------------------------------------------
`include "im2col_gather_unit_defines.svh"

module im2col_gather_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [icg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icg_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  icg_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output icg_pkg::result_t                result
);
  import icg_pkg::*;

  // Configuration registers, reset to their defaults
  cfg_t  cfg;
  logic  cfg_start;

  // Output size derivation
  dims_t dims;
  logic  dim_busy;

  // Pipeline control: the whole pipe moves when the output stage can take
  logic  advance;
  logic  accept;

  // Store stage
  mem_req_t          req;
  logic              addr_ok;
  logic              waddr_ok;
  logic              addr_oob;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       ram_rdata;

  // Output stage
  logic        res_valid;
  logic        res_ok;
  logic        res_err;
  logic        res_pad;
  logic [31:0] res_cidx;

  // --------------------------------------------------------------------------
  // Configuration port: every write in the register list restarts derivation,
  // writes beyond the list are dropped.
  // --------------------------------------------------------------------------
  always_comb begin
    case (cfg_index)
      REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH, REG_CHANNEL_COUNT,
      REG_KERNEL_SIZE, REG_STEP_SIZE, REG_PADDING: begin
        cfg_start = cfg_we;
      end
      default: begin
        cfg_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_height  <= 9'd1;
      cfg.image_width   <= 9'd1;
      cfg.channel_count <= 9'd1;
      cfg.kernel_size   <= 5'd1;
      cfg.step_size     <= 5'd1;
      cfg.padding       <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data;
        REG_KERNEL_SIZE:   cfg.kernel_size   <= cfg_data[4:0];
        REG_STEP_SIZE:     cfg.step_size     <= cfg_data[4:0];
        REG_PADDING:       cfg.padding       <= cfg_data[3:0];
        default: begin
          cfg.padding <= cfg.padding;
        end
      endcase
    end
  end

  icg_dim_unit u_dim (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_start),
    .cfg   (cfg),
    .dims  (dims),
    .busy  (dim_busy)
  );

  // --------------------------------------------------------------------------
  // Input side: hold off while the output stage is full and not drained,
  // during a configuration write and while output sizes are being derived.
  // --------------------------------------------------------------------------
  assign advance    = !res_valid || result_ready;
  assign item_ready = advance && !dim_busy && !cfg_we;
  assign accept     = item_valid && item_ready;

  icg_fetch_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .accept  (accept),
    .item    (item),
    .cfg     (cfg),
    .dims    (dims),
    .req     (req)
  );

  // --------------------------------------------------------------------------
  // Store stage. Writes and reads meet the store at the same stage, so item
  // order alone keeps a read after a write to the same word correct.
  // --------------------------------------------------------------------------
  assign addr_ok  = {5'b0, req.addr_full} < IMAGE_WORDS;
  assign waddr_ok = {16'b0, req.waddr} < IMAGE_WORDS;
  assign addr_oob = !req.err && !req.pad && !addr_ok;
  assign ram_we   = req.valid && !req.is_fetch && waddr_ok;
  assign ram_addr = req.is_fetch ? req.addr_full[ADDR_W-1:0] : ADDR_W'(req.waddr);

  icg_ram #(
    .DEPTH (IMAGE_WORDS),
    .WIDTH (32)
  ) u_store (
    .clk   (clk),
    .en    (advance),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req.wdata),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Output stage: only fetches produce a transfer; writes drop out here.
  // A rejected fetch carries zeros; a border fetch carries its index only.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req.valid && req.is_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_err  <= req.err || addr_oob;
      res_pad  <= !req.err && req.pad;
      res_ok   <= !req.err && !req.pad && addr_ok;
      res_cidx <= (req.err || addr_oob) ? 32'd0 : req.prod + {14'b0, req.pos};
    end
  end

  assign result_valid         = res_valid;
  assign result.element_value = res_ok ? ram_rdata : 32'd0;
  assign result.column_index  = res_cidx;
  assign result.is_padding    = res_pad;
  assign result.range_error   = res_err;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ICG_ASSERT_NOW(a_flags_exclusive, result_valid,
                  !(result.is_padding && result.range_error),
                  "padding and range error flagged together")
  `ICG_ASSERT_NOW(a_error_zeroed, result_valid && result.range_error,
                  (result.element_value == 32'd0) && (result.column_index == 32'd0),
                  "rejected fetch carries nonzero fields")
  `ICG_ASSERT_NOW(a_pad_zero, result_valid && result.is_padding,
                  result.element_value == 32'd0,
                  "border fetch carries nonzero value")
  `ICG_ASSERT_NOW(a_busy_blocks_input, dim_busy, !item_ready,
                  "input taken while output size is being derived")
  `ICG_ASSERT_NEXT(a_cfg_starts_derive,
                   cfg_we && (cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_IMAGE_WIDTH ||
                   cfg_index == REG_CHANNEL_COUNT || cfg_index == REG_KERNEL_SIZE ||
                   cfg_index == REG_STEP_SIZE || cfg_index == REG_PADDING),
                   dim_busy, "configuration write did not start derivation")

endmodule
